### rtl/core/lru_tracker_with_pinning_assert.svh
// Assertion macros used by the recency tracker RTL.
`ifndef LRU_TRACKER_WITH_PINNING_ASSERT_SVH
`define LRU_TRACKER_WITH_PINNING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRUT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lru tracker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LRUT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lru tracker assertion failed");

`endif

### rtl/core/lrut_pkg.sv
// Package with sizes, operation codes, status codes and shared types of the recency tracker.
package lrut_pkg;

	localparam int CAPACITY     = 64;
	localparam int PIN_CAPACITY = 64;
	localparam int AGE_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W        = $clog2(CAPACITY + 1);
	localparam int KEY_W        = 32;
	localparam int OP_W         = 3;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 7;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_TOUCH  = 3'd2;
	localparam logic [OP_W-1:0] OP_PIN    = 3'd3;
	localparam logic [OP_W-1:0] OP_UNPIN  = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PIN_FULL = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic match;
		logic update;
		logic report;
	} lrut_cmd_t;

endpackage

### rtl/core/lrut_if.sv
// Handshake interfaces for the request and response channels of the recency tracker.
interface lrut_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [31:0] key;
	modport source (output valid, output operation, output key, input ready);
	modport sink (input valid, input operation, input key, output ready);
endinterface

interface lrut_rsp_if;
	logic        valid;
	logic        ready;
	logic        present;
	logic        pinned;
	logic        oldest_valid;
	logic [31:0] oldest_key;
	logic [6:0]  entry_count;
	logic [1:0]  status;
	modport source (output valid, output present, output pinned, output oldest_valid,
		output oldest_key, output entry_count, output status, input ready);
	modport sink (input valid, input present, input pinned, input oldest_valid,
		input oldest_key, input entry_count, input status, output ready);
endinterface

### rtl/core/lrut_datapath.sv
// Datapath of the recency tracker: key cells, ages, pinned cells and the result register.
module lrut_datapath import lrut_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  lrut_cmd_t           cmd,
	input  logic [OP_W-1:0]     operation,
	input  logic [KEY_W-1:0]    key,
	output logic                present,
	output logic                pinned,
	output logic                oldest_valid,
	output logic [KEY_W-1:0]    oldest_key,
	output logic [COUNT_W-1:0]  entry_count,
	output logic [STATUS_W-1:0] status
);

	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [KEY_W-1:0]    keys_q [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [AGE_W-1:0]    age_q [CAPACITY];
	logic [KEY_W-1:0]    pkeys_q [PIN_CAPACITY];
	logic [PIN_CAPACITY-1:0] pvalid_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [CAPACITY-1:0]     hit_c;
	logic [PIN_CAPACITY-1:0] phit_c;
	logic [AGE_W-1:0]        hit_age_c;
	logic [KEY_W-1:0]        oldest_c;

	logic [CAPACITY-1:0]     hit_s1;
	logic [CAPACITY-1:0]     efree_s1;
	logic                    efull_s1;
	logic [AGE_W-1:0]        hit_age_s1;
	logic                    phit_s1;
	logic [PIN_CAPACITY-1:0] pfree_s1;
	logic                    pfull_s1;

	logic                do_newest, do_drop, do_ins, do_pin_add, do_unpin, do_clear;
	logic [STATUS_W-1:0] st_c;

	logic                present_q, pinned_q, oldest_valid_q;
	logic [KEY_W-1:0]    oldest_key_q;
	logic [COUNT_W-1:0]  count_q;
	logic [STATUS_W-1:0] status_q, status_s2;

	// Parallel compare of the held key against every cell.
	always_comb begin
		hit_age_c = '0;
		oldest_c  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_c[i] = valid_q[i] && (keys_q[i] == key_q);
			if (hit_c[i])
				hit_age_c = hit_age_c | age_q[i];
			if (valid_q[i] && (age_q[i] == '0))
				oldest_c = oldest_c | keys_q[i];
		end
		for (int j = 0; j < PIN_CAPACITY; j++)
			phit_c[j] = pvalid_q[j] && (pkeys_q[j] == key_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			key_q <= key;
		end
		if (cmd.match) begin
			hit_s1     <= hit_c;
			hit_age_s1 <= hit_age_c;
			efree_s1   <= ~valid_q & (valid_q + CAPACITY'(1));
			efull_s1   <= &valid_q;
			phit_s1    <= |phit_c;
			pfree_s1   <= ~pvalid_q & (pvalid_q + PIN_CAPACITY'(1));
			pfull_s1   <= &pvalid_q;
		end
	end

	// Decode of the operation against the match results.
	always_comb begin
		do_newest  = 1'b0;
		do_drop    = 1'b0;
		do_ins     = 1'b0;
		do_pin_add = 1'b0;
		do_unpin   = 1'b0;
		do_clear   = 1'b0;
		st_c       = ST_OK;
		case (op_q)
			OP_INSERT: begin
				if (|hit_s1)
					do_newest = 1'b1;
				else if (efull_s1)
					st_c = ST_FULL;
				else
					do_ins = 1'b1;
			end
			OP_REMOVE: do_drop = |hit_s1;
			OP_TOUCH:  do_newest = |hit_s1;
			OP_PIN: begin
				if (!phit_s1 && pfull_s1) begin
					st_c = ST_PIN_FULL;
				end else begin
					do_pin_add = !phit_s1;
					do_drop    = |hit_s1;
				end
			end
			OP_UNPIN:  do_unpin = phit_s1;
			OP_CLEAR:  do_clear = 1'b1;
			default:   st_c = ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			status_s2 <= st_c;
			for (int i = 0; i < CAPACITY; i++)
				if (do_ins && efree_s1[i])
					keys_q[i] <= key_q;
			for (int j = 0; j < PIN_CAPACITY; j++)
				if (do_pin_add && pfree_s1[j])
					pkeys_q[j] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			pvalid_q <= '0;
			cnt_q    <= '0;
			for (int i = 0; i < CAPACITY; i++)
				age_q[i] <= '0;
		end else if (cmd.update) begin
			if (do_clear) begin
				valid_q  <= '0;
				pvalid_q <= '0;
				cnt_q    <= '0;
				for (int i = 0; i < CAPACITY; i++)
					age_q[i] <= '0;
			end else begin
				for (int i = 0; i < CAPACITY; i++) begin
					// Entries younger than the moved or dropped one step one rank older.
					if ((do_newest || do_drop) && valid_q[i] && (age_q[i] > hit_age_s1))
						age_q[i] <= age_q[i] - AGE_W'(1);
					if (do_newest && hit_s1[i])
						age_q[i] <= AGE_W'(cnt_q - CNT_W'(1));
					if (do_drop && hit_s1[i])
						valid_q[i] <= 1'b0;
					if (do_ins && efree_s1[i]) begin
						valid_q[i] <= 1'b1;
						age_q[i]   <= AGE_W'(cnt_q);
					end
				end
				if (do_ins)
					cnt_q <= cnt_q + CNT_W'(1);
				else if (do_drop)
					cnt_q <= cnt_q - CNT_W'(1);
				for (int j = 0; j < PIN_CAPACITY; j++) begin
					if (do_unpin && phit_c[j])
						pvalid_q[j] <= 1'b0;
					if (do_pin_add && pfree_s1[j])
						pvalid_q[j] <= 1'b1;
				end
			end
		end
	end

	// The result is read from the updated state.
	always_ff @(posedge clk) begin
		if (cmd.report) begin
			present_q      <= |hit_c;
			pinned_q       <= |phit_c;
			oldest_valid_q <= |valid_q;
			oldest_key_q   <= oldest_c;
			count_q        <= COUNT_W'(cnt_q);
			status_q       <= status_s2;
		end
	end

	assign present      = present_q;
	assign pinned       = pinned_q;
	assign oldest_valid = oldest_valid_q;
	assign oldest_key   = oldest_key_q;
	assign entry_count  = count_q;
	assign status       = status_q;

endmodule

### rtl/core/lrut_ctrl.sv
// Controller state machine of the recency tracker.
module lrut_ctrl import lrut_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output lrut_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_MATCH  = 4'b0010,
		S_UPDATE = 4'b0100,
		S_REPORT = 4'b1000
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   report_go;

	assign report_go = (state_q == S_REPORT) && (!rsp_valid_q || rsp_ready);
	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.load   = req_ready && req_valid;
		cmd.match  = (state_q == S_MATCH);
		cmd.update = (state_q == S_UPDATE);
		cmd.report = report_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (report_go)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:   if (req_valid) state_q <= S_MATCH;
				S_MATCH:  state_q <= S_UPDATE;
				S_UPDATE: state_q <= S_REPORT;
				S_REPORT: if (report_go) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

### rtl/core/lru_tracker_with_pinning.sv
// Top level of the recency tracker with a pinned key set.
//
//  channel | direction | payload
//  req     | in        | operation, key
//  rsp     | out       | present, pinned, oldest_valid, oldest_key, entry_count, status
//
// Each transaction on req runs through capture, a parallel compare of the key
// against all recency and pinned cells, the update of valid bits, ages and count, and
// a second compare that loads the result register. The single shared compare array serves
// both compares, so a new request is taken only after the last one has left its report step.
// Reset clears all valid bits, ages and the count; the key cells hold no reset value.
// A result waiting on rsp does not block the next request; only its report step waits.
`include "lru_tracker_with_pinning_assert.svh"

module lru_tracker_with_pinning import lrut_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	lrut_req_if.sink    req,
	lrut_rsp_if.source  rsp
);

	lrut_cmd_t cmd;

	// The controller sequences the steps and owns both handshakes.
	lrut_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// The datapath holds the tables and the result register.
	lrut_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.operation    (req.operation),
		.key          (req.key),
		.present      (rsp.present),
		.pinned       (rsp.pinned),
		.oldest_valid (rsp.oldest_valid),
		.oldest_key   (rsp.oldest_key),
		.entry_count  (rsp.entry_count),
		.status       (rsp.status)
	);

	// One request is in work at a time.
	`LRUT_ASSERT_NEXT(a_one_in_work, req.valid && req.ready, !req.ready)
	// The oldest key is reported exactly when the recency set holds something.
	`LRUT_ASSERT_NOW(a_oldest_count, rsp.valid, rsp.oldest_valid == (rsp.entry_count != 7'd0))
	// A dropped insert leaves the key absent.
	`LRUT_ASSERT_NOW(a_drop_absent, rsp.valid && (rsp.status == ST_FULL), !rsp.present)
	// The count never passes the capacity.
	`LRUT_ASSERT_NOW(a_count_cap, rsp.valid, rsp.entry_count <= COUNT_W'(CAPACITY))

endmodule

### tb/lrut_tb_if.sv
// Testbench copy note: interfaces come from the RTL; this file holds the item types used by the tb.
`timescale 1ns / 100ps
package lrut_tb_pkg;
	import lrut_pkg::*;

	// One result of the tracker as the predictor computes it.
	typedef struct packed {
		logic                present;
		logic                pinned;
		logic                oldest_valid;
		logic [KEY_W-1:0]    oldest_key;
		logic [COUNT_W-1:0]  entry_count;
		logic [STATUS_W-1:0] status;
	} lookup_result_t;

	// One request to the tracker.
	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [KEY_W-1:0] key;
	} table_op_t;
endpackage

### tb/tb.sv
// Testbench top for the recency tracker: random table operations checked against a predictor.
`timescale 1ns / 100ps
module tb;
	import lrut_pkg::*;
	import lrut_tb_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lrut_req_if req ();
	lrut_rsp_if rsp ();

	lru_tracker_with_pinning DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always #1 clk = ~clk;

	// Predictor state: a slot array with ranks, mirroring what the block keeps.
	logic [KEY_W-1:0] slot_key [CAPACITY];
	bit               slot_used [CAPACITY];
	int unsigned      slot_rank [CAPACITY];
	logic [KEY_W-1:0] pin_key [PIN_CAPACITY];
	bit               pin_used [PIN_CAPACITY];
	int unsigned      live_keys;

	table_op_t      pending_ops [$];
	lookup_result_t expected_results [$];
	bit             failed = 1'b0;
	bit             hold_sender = 1'b0;
	int             idle_cycles = 0;
	int             send_gap = 0;
	int             recv_gap = 0;

	// Small key pool so that hits, refills and full sets happen often.
	logic [KEY_W-1:0] key_pool [96];

	function automatic int find_slot(logic [KEY_W-1:0] k);
		for (int i = 0; i < CAPACITY; i++)
			if (slot_used[i] && slot_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic int find_pinned(logic [KEY_W-1:0] k);
		for (int i = 0; i < PIN_CAPACITY; i++)
			if (pin_used[i] && pin_key[i] == k)
				return i;
		return -1;
	endfunction

	// Every entry younger than the given rank moves one step older.
	function automatic void close_rank_gap(int unsigned r);
		for (int i = 0; i < CAPACITY; i++)
			if (slot_used[i] && slot_rank[i] > r)
				slot_rank[i]--;
	endfunction

	function automatic void promote_slot(int s);
		close_rank_gap(slot_rank[s]);
		slot_rank[s] = live_keys - 1;
	endfunction

	function automatic void evict_slot(int s);
		slot_used[s] = 1'b0;
		close_rank_gap(slot_rank[s]);
		live_keys--;
	endfunction

	function automatic int first_free_slot();
		for (int i = 0; i < CAPACITY; i++)
			if (!slot_used[i])
				return i;
		return -1;
	endfunction

	function automatic int first_free_pin();
		for (int i = 0; i < PIN_CAPACITY; i++)
			if (!pin_used[i])
				return i;
		return -1;
	endfunction

	// Applies one operation to the predicted tables and returns the expected result.
	function automatic lookup_result_t apply_table_op(table_op_t t);
		lookup_result_t r;
		int s;
		int p;
		int f;
		r = '0;
		r.status = ST_OK;
		s = find_slot(t.key);
		case (t.operation)
			OP_INSERT: begin
				if (s >= 0) begin
					promote_slot(s);
				end else begin
					f = first_free_slot();
					if (f >= 0) begin
						slot_used[f] = 1'b1;
						slot_key[f] = t.key;
						slot_rank[f] = live_keys;
						live_keys++;
					end else begin
						r.status = ST_FULL;
					end
				end
			end
			OP_REMOVE: begin
				if (s >= 0)
					evict_slot(s);
			end
			OP_TOUCH: begin
				if (s >= 0)
					promote_slot(s);
			end
			OP_PIN: begin
				p = find_pinned(t.key);
				if (p < 0) begin
					f = first_free_pin();
					if (f >= 0) begin
						pin_used[f] = 1'b1;
						pin_key[f] = t.key;
					end else begin
						r.status = ST_PIN_FULL;
					end
				end
				// A dropped pin leaves the key where it was in the recency set.
				if (r.status == ST_OK && s >= 0)
					evict_slot(s);
			end
			OP_UNPIN: begin
				p = find_pinned(t.key);
				if (p >= 0)
					pin_used[p] = 1'b0;
			end
			OP_CLEAR: begin
				for (int i = 0; i < CAPACITY; i++) begin
					slot_used[i] = 1'b0;
					slot_rank[i] = 0;
				end
				for (int i = 0; i < PIN_CAPACITY; i++)
					pin_used[i] = 1'b0;
				live_keys = 0;
			end
			default: begin
			end
		endcase
		for (int i = 0; i < CAPACITY; i++) begin
			if (slot_used[i] && slot_rank[i] == 0) begin
				r.oldest_valid = 1'b1;
				r.oldest_key = slot_key[i];
				break;
			end
		end
		r.present = find_slot(t.key) >= 0;
		r.pinned = find_pinned(t.key) >= 0;
		r.entry_count = live_keys[COUNT_W-1:0];
		return r;
	endfunction

	// Gap length: mostly zero or short, now and then long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		if (roll < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic void queue_op(logic [OP_W-1:0] o, logic [KEY_W-1:0] k);
		table_op_t t;
		t.operation = o;
		t.key = k;
		pending_ops.push_back(t);
	endfunction

	function automatic logic [OP_W-1:0] random_op();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40) return OP_INSERT;
		if (roll < 55) return OP_REMOVE;
		if (roll < 70) return OP_TOUCH;
		if (roll < 82) return OP_PIN;
		if (roll < 94) return OP_UNPIN;
		if (roll < 96) return OP_CLEAR;
		return 3'($urandom_range(7, 6));
	endfunction

	// Driver: the prediction is made at acceptance so it follows the accepted order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.operation <= '0;
			req.key <= '0;
			send_gap <= 0;
		end else begin
			if (req.valid && req.ready) begin
				expected_results.push_back(apply_table_op({req.operation, req.key}));
				void'(pending_ops.pop_front());
			end
			if (req.valid && !(req.ready)) begin
				// Hold the transaction until it is taken.
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				req.valid <= 1'b0;
			end else begin
				// The head just taken is gone, so look one further when it was popped.
				if (pending_ops.size() > 0 && !hold_sender) begin
					req.valid <= 1'b1;
					req.operation <= pending_ops[0].operation;
					req.key <= pending_ops[0].key;
					send_gap <= pick_gap();
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random stalls on the result side and a field-by-field compare.
	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no transaction outstanding");
					failed = 1'b1;
				end else begin
					want = expected_results.pop_front();
					if (rsp.present !== want.present) begin
						$error("present: expected %0d, got %0d", want.present, rsp.present);
						failed = 1'b1;
					end
					if (rsp.pinned !== want.pinned) begin
						$error("pinned: expected %0d, got %0d", want.pinned, rsp.pinned);
						failed = 1'b1;
					end
					if (rsp.oldest_valid !== want.oldest_valid) begin
						$error("oldest_valid: expected %0d, got %0d", want.oldest_valid,
							rsp.oldest_valid);
						failed = 1'b1;
					end
					if (rsp.oldest_key !== want.oldest_key) begin
						$error("oldest_key: expected %h, got %h", want.oldest_key,
							rsp.oldest_key);
						failed = 1'b1;
					end
					if (rsp.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d", want.entry_count,
							rsp.entry_count);
						failed = 1'b1;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						failed = 1'b1;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if (rsp.valid && rsp.ready)
					recv_gap <= pick_gap();
			end
		end
	end

	// Watchdog: counts cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int burst;
		int n;
		logic [KEY_W-1:0] k;
		for (int i = 0; i < CAPACITY; i++) begin
			slot_used[i] = 1'b0;
			slot_rank[i] = 0;
			slot_key[i] = '0;
		end
		for (int i = 0; i < PIN_CAPACITY; i++) begin
			pin_used[i] = 1'b0;
			pin_key[i] = '0;
		end
		live_keys = 0;
		for (int i = 0; i < 96; i++)
			key_pool[i] = $urandom();
		key_pool[0] = '0;
		key_pool[1] = '1;

		// Directed: key extremes, every operation, absent keys and odd op codes.
		queue_op(OP_INSERT, 32'h0);
		queue_op(OP_INSERT, 32'hFFFF_FFFF);
		queue_op(OP_INSERT, 32'h0);
		queue_op(OP_TOUCH, 32'hFFFF_FFFF);
		queue_op(OP_TOUCH, 32'h1234_5678);
		queue_op(OP_REMOVE, 32'h8000_0000);
		queue_op(OP_PIN, 32'h0);
		queue_op(OP_PIN, 32'h0);
		queue_op(OP_PIN, 32'h5555_AAAA);
		queue_op(OP_INSERT, 32'h0);
		queue_op(OP_UNPIN, 32'h0);
		queue_op(OP_UNPIN, 32'h0);
		queue_op(3'd6, 32'hFFFF_FFFF);
		queue_op(3'd7, 32'h0);
		queue_op(OP_REMOVE, 32'hFFFF_FFFF);
		queue_op(OP_CLEAR, 32'hAAAA_5555);

		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Fill both sets past capacity so the full-set drops show up.
		for (int i = 0; i < CAPACITY + 3; i++)
			queue_op(OP_INSERT, 32'h1000 + i);
		for (int i = 0; i < 5; i++)
			queue_op(OP_PIN, 32'h1000 + i);
		for (int i = 0; i < PIN_CAPACITY + 2; i++)
			queue_op(OP_PIN, 32'h2000 + i);
		queue_op(OP_PIN, 32'h1010);
		queue_op(OP_UNPIN, 32'h2000);
		queue_op(OP_PIN, 32'h1010);

		// Let everything drain once before the random part.
		wait (pending_ops.size() == 0);
		hold_sender = 1'b1;
		wait (expected_results.size() == 0);
		hold_sender = 1'b0;

		// Random part: bursts on a small pool, fill bursts, and full-range keys.
		n = 0;
		while (n < 1400) begin
			burst = $urandom_range(3);
			if (burst == 0) begin
				for (int i = 0; i < 70; i++) begin
					queue_op(OP_INSERT, key_pool[$urandom_range(95)]);
					n++;
				end
			end else begin
				for (int i = 0; i < 40; i++) begin
					if ($urandom_range(9) == 0)
						k = $urandom();
					else
						k = key_pool[$urandom_range(95)];
					queue_op(random_op(), k);
					n++;
				end
			end
			wait (pending_ops.size() < 20);
		end
		wait (pending_ops.size() == 0);
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed && expected_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

### files.f
+incdir+rtl/core
rtl/core/lrut_pkg.sv
rtl/core/lrut_if.sv
rtl/core/lrut_datapath.sv
rtl/core/lrut_ctrl.sv
rtl/core/lru_tracker_with_pinning.sv
tb/lrut_tb_if.sv
tb/tb.sv
